[hw/rtl/assert_macros.svh]
// Assertion macros shared by the checker files.
// Clock and reset names clk_i and rst_ni must be visible where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert a property on every rising clock edge outside reset.
`define NTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Assert that a condition implies another in the same cycle.
`define NTC_IMPLIES(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) else $error(msg);
`endif

[hw/rtl/ntc_pkg.sv]
// Shared constants, types and helper functions for the NTC temperature block.
// No dependencies.
package ntc_pkg;

  localparam int SIG_W     = 15;
  localparam int TEMP_W    = 16;
  localparam int BETA_W    = 16;
  localparam int RES_W     = 20;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_BETA     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOM_TEMP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SERIES   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NOM_RES  = 2'd3;

  localparam logic [BETA_W-1:0] BETA_RST     = 16'd3950;
  localparam logic [TEMP_W-1:0] NOM_TEMP_RST = 16'd6400;
  localparam logic [RES_W-1:0]  SERIES_RST   = 20'd10000;
  localparam logic [RES_W-1:0]  NOM_RES_RST  = 20'd10000;

  localparam int FRAC_BITS_DEF = 8;

  // Resistance products, log2 and the ln2 scaling
  localparam int XY_W     = SIG_W + RES_W;
  localparam int POS_W    = 6;
  localparam int MANT_W   = 32;
  localparam int LOG_FRAC = 24;
  localparam int LOG_W    = POS_W + LOG_FRAC;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam int PROD_W   = 62;
  localparam int DEN1_W   = 32;
  localparam int TERM_W   = 46;

  typedef struct packed {
    logic valid;
    logic invalid;
    logic flag;
  } ntc_side_t;

  // Position of the leading one.
  function automatic logic [POS_W-1:0] lead_pos(input logic [XY_W-1:0] x);
    logic [POS_W-1:0] p;
    p = '0;
    for (int i = 0; i < XY_W; i++) begin
      if (x[i]) p = POS_W'(i);
    end
    return p;
  endfunction

  // Align the leading one to bit MANT_W-1 (Q31 mantissa), truncating.
  function automatic logic [MANT_W-1:0] mant_norm(input logic [XY_W-1:0] x,
                                                  input logic [POS_W-1:0] pos);
    logic [XY_W+MANT_W-1:0] w;
    w = (XY_W+MANT_W)'(x);
    if (pos <= POS_W'(MANT_W-1)) begin
      w = w << (POS_W'(MANT_W-1) - pos);
    end else begin
      w = w >> (pos - POS_W'(MANT_W-1));
    end
    return w[MANT_W-1:0];
  endfunction

endpackage

[hw/rtl/ntc_log_cell.sv]
// One squaring step of the log2 fraction chain.
// Depends on ntc_pkg.
module ntc_log_cell import ntc_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [MANT_W-1:0]   m_i,
  input  logic [LOG_FRAC-1:0] frac_i,
  output logic [MANT_W-1:0]   m_o,
  output logic [LOG_FRAC-1:0] frac_o
);

  logic [2*MANT_W-1:0] sq;
  logic [MANT_W:0]     sh;
  logic [MANT_W-1:0]   m_d;
  logic                bit_d;
  logic [MANT_W-1:0]   m_q;
  logic [LOG_FRAC-1:0] frac_q;

  always_comb begin
    sq    = m_i * m_i;
    sh    = sq[2*MANT_W-1:MANT_W-1];
    bit_d = sh[MANT_W];
    m_d   = bit_d ? sh[MANT_W:1] : sh[MANT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q    <= m_d;
      frac_q <= {frac_i[LOG_FRAC-2:0], bit_d};
    end
  end

  assign m_o    = m_q;
  assign frac_o = frac_q;

endmodule

[hw/rtl/ntc_div_cell.sv]
// One restoring division step: one quotient bit per cell.
// No package dependencies.
module ntc_div_cell #(
  parameter int NUM_W = 62,
  parameter int DEN_W = 32
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [NUM_W-1:0] quo_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] num_o,
  output logic [DEN_W-1:0] rem_o,
  output logic [NUM_W-1:0] quo_o,
  output logic [DEN_W-1:0] den_o
);

  logic [DEN_W:0]   sh;
  logic [DEN_W:0]   diff;
  logic             ge;
  logic [NUM_W-1:0] num_q;
  logic [DEN_W-1:0] rem_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] den_q;

  always_comb begin
    sh   = {rem_i, num_i[NUM_W-1]};
    ge   = sh >= {1'b0, den_i};
    diff = sh - {1'b0, den_i};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= {num_i[NUM_W-2:0], 1'b0};
      rem_q <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
      quo_q <= {quo_i[NUM_W-2:0], ge};
      den_q <= den_i;
    end
  end

  assign num_o = num_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;
  assign den_o = den_q;

endmodule

[hw/rtl/ntc_thermistor_temperature.sv]
// NTC thermistor temperature by the beta equation, top level.
// Depends on ntc_pkg, ntc_log_cell and ntc_div_cell.
//
// Input channel: in_valid_i / in_stall_o carry a pair of ADC codes (divider
// signal and divider reference). Output channel: out_valid_o / out_stall_i
// carry the temperature in signed 2^-FRAC_BITS degC steps plus an invalid flag.
// Configuration: cfg_we_i writes cfg_data_i into the register at cfg_index_i
// (beta, nominal temperature, series resistor, nominal resistance); write only
// while no transfer is in flight.
// The datapath is a chain of cells that all advance together: four front
// stages, 24 log2 squaring cells, two scaling stages, 62 division cells for
// the ln term and 1/T0, one combine stage, FRAC_BITS+43 division cells for
// the final reciprocal (FRAC_BITS of 5 or more), and the output register.
// One transfer per cycle is accepted while the chain is not stalled.
// Stall: when the output register holds a result the receiver stalls, the
// whole chain freezes and in_stall_o rises in the same cycle; nothing is lost.
// Reset clears all valid bits and loads the register defaults.
module ntc_thermistor_temperature import ntc_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [SIG_W-1:0]            signal_code_i,
  input  logic [SIG_W-1:0]            reference_code_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [TEMP_W-1:0]    temperature_out_o,
  output logic                        invalid_o,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CFG_W-1:0]            cfg_data_i
);

  localparam int ONE_W = 41 + FRAC_BITS;
  localparam int INV_W = ((ONE_W > TERM_W) ? ONE_W : TERM_W) + 1;
  localparam int TK_W  = INV_W + 1;
  localparam int unsigned KOFF = (2731 * (1 << FRAC_BITS) + 5) / 10;
  localparam logic [ONE_W-1:0] ONE = {1'b1, {(ONE_W-1){1'b0}}};

  // Configuration registers
  logic [BETA_W-1:0] beta_q;
  logic [TEMP_W-1:0] nom_temp_q;
  logic [RES_W-1:0]  series_q;
  logic [RES_W-1:0]  nom_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beta_q     <= BETA_RST;
      nom_temp_q <= NOM_TEMP_RST;
      series_q   <= SERIES_RST;
      nom_res_q  <= NOM_RES_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_BETA:     beta_q     <= cfg_data_i[BETA_W-1:0];
        CFG_NOM_TEMP: nom_temp_q <= cfg_data_i[TEMP_W-1:0];
        CFG_SERIES:   series_q   <= cfg_data_i[RES_W-1:0];
        CFG_NOM_RES:  nom_res_q  <= cfg_data_i[RES_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero beta and resistor registers act as one
  logic [BETA_W-1:0] beta_c;
  logic [RES_W-1:0]  series_c;
  logic [RES_W-1:0]  nom_res_c;
  assign beta_c    = (beta_q == '0) ? BETA_W'(1) : beta_q;
  assign series_c  = (series_q == '0) ? RES_W'(1) : series_q;
  assign nom_res_c = (nom_res_q == '0) ? RES_W'(1) : nom_res_q;

  // Advance the whole chain unless the output register is full and stalled
  logic en;
  logic out_valid_q;
  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;

  // Stage A: input capture
  logic             a_valid_q;
  logic [SIG_W-1:0] a_sig_q;
  logic [SIG_W-1:0] a_ref_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (en) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && in_valid_i) begin
      a_sig_q <= signal_code_i;
      a_ref_q <= reference_code_i;
    end
  end

  // Stage B: resistance products and the range check
  ntc_side_t       b_side_q;
  logic [XY_W-1:0] b_x_q;
  logic [XY_W-1:0] b_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_side_q <= '0;
    end else if (en) begin
      b_side_q.valid   <= a_valid_q;
      b_side_q.invalid <= (a_sig_q == '0) || (a_sig_q >= a_ref_q);
      b_side_q.flag    <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_x_q <= XY_W'(series_c) * XY_W'(a_sig_q);
      b_y_q <= XY_W'(a_ref_q - a_sig_q) * XY_W'(nom_res_c);
    end
  end

  // Stage C: leading-one positions
  ntc_side_t        c_side_q;
  logic [XY_W-1:0]  c_x_q;
  logic [XY_W-1:0]  c_y_q;
  logic [POS_W-1:0] c_posx_q;
  logic [POS_W-1:0] c_posy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_side_q <= '0;
    end else if (en) begin
      c_side_q <= b_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_x_q    <= b_x_q;
      c_y_q    <= b_y_q;
      c_posx_q <= lead_pos(b_x_q);
      c_posy_q <= lead_pos(b_y_q);
    end
  end

  // Stage D and log2 chain: index 0 is the normalized mantissa
  logic [MANT_W-1:0]   lmx   [0:LOG_FRAC];
  logic [MANT_W-1:0]   lmy   [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] lfx   [0:LOG_FRAC];
  logic [LOG_FRAC-1:0] lfy   [0:LOG_FRAC];
  logic [POS_W-1:0]    lposx [0:LOG_FRAC];
  logic [POS_W-1:0]    lposy [0:LOG_FRAC];
  ntc_side_t           lside [0:LOG_FRAC];
  logic [MANT_W-1:0]   d_mx_q;
  logic [MANT_W-1:0]   d_my_q;
  logic [POS_W-1:0]    d_posx_q;
  logic [POS_W-1:0]    d_posy_q;
  ntc_side_t           d_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_side_q <= '0;
    end else if (en) begin
      d_side_q <= c_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_mx_q   <= mant_norm(c_x_q, c_posx_q);
      d_my_q   <= mant_norm(c_y_q, c_posy_q);
      d_posx_q <= c_posx_q;
      d_posy_q <= c_posy_q;
    end
  end

  assign lmx[0]   = d_mx_q;
  assign lmy[0]   = d_my_q;
  assign lfx[0]   = '0;
  assign lfy[0]   = '0;
  assign lposx[0] = d_posx_q;
  assign lposy[0] = d_posy_q;
  assign lside[0] = d_side_q;

  for (genvar i = 0; i < LOG_FRAC; i++) begin : g_log
    ntc_side_t        side_q;
    logic [POS_W-1:0] posx_q;
    logic [POS_W-1:0] posy_q;

    ntc_log_cell u_cell_x (
      .clk_i, .en_i(en), .m_i(lmx[i]), .frac_i(lfx[i]),
      .m_o(lmx[i+1]), .frac_o(lfx[i+1])
    );
    ntc_log_cell u_cell_y (
      .clk_i, .en_i(en), .m_i(lmy[i]), .frac_i(lfy[i]),
      .m_o(lmy[i+1]), .frac_o(lfy[i+1])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q <= '0;
      end else if (en) begin
        side_q <= lside[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        posx_q <= lposx[i];
        posy_q <= lposy[i];
      end
    end

    assign lside[i+1] = side_q;
    assign lposx[i+1] = posx_q;
    assign lposy[i+1] = posy_q;
  end

  // Stage E: log difference, sign kept in the side flag
  logic [LOG_W-1:0] lx_c;
  logic [LOG_W-1:0] ly_c;
  ntc_side_t        e_side_q;
  logic [LOG_W-1:0] e_mag_q;

  assign lx_c = {lposx[LOG_FRAC], lfx[LOG_FRAC]};
  assign ly_c = {lposy[LOG_FRAC], lfy[LOG_FRAC]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_side_q <= '0;
    end else if (en) begin
      e_side_q.valid   <= lside[LOG_FRAC].valid;
      e_side_q.invalid <= lside[LOG_FRAC].invalid;
      e_side_q.flag    <= lx_c < ly_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_mag_q <= (lx_c < ly_c) ? (ly_c - lx_c) : (lx_c - ly_c);
    end
  end

  // Stage F: scale by ln2, set up both dividers
  logic signed [31:0] t0k_s;
  logic [DEN1_W-1:0]  t0k_c;
  ntc_side_t          f_side_q;
  logic [PROD_W-1:0]  f_tnum_q;
  logic [DEN1_W-1:0]  f_tden_q;
  logic [PROD_W-1:0]  f_inum_q;
  logic [DEN1_W-1:0]  f_iden_q;

  always_comb begin
    t0k_s = 32'($signed(nom_temp_q)) + $signed(32'(KOFF));
    t0k_c = (t0k_s < 32'sd1) ? DEN1_W'(1) : DEN1_W'(t0k_s);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_side_q <= '0;
    end else if (en) begin
      f_side_q <= e_side_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_tnum_q <= PROD_W'(e_mag_q) * PROD_W'(LN2_Q32) + (PROD_W'(beta_c) << 15);
      f_tden_q <= DEN1_W'(beta_c) << 16;
      f_inum_q <= PROD_W'(ONE) + PROD_W'(t0k_c >> 1);
      f_iden_q <= t0k_c;
    end
  end

  // Division chain for the ln term and for 1/T0
  logic [PROD_W-1:0] tn [0:PROD_W];
  logic [DEN1_W-1:0] tr [0:PROD_W];
  logic [PROD_W-1:0] tq [0:PROD_W];
  logic [DEN1_W-1:0] td [0:PROD_W];
  logic [PROD_W-1:0] vn [0:PROD_W];
  logic [DEN1_W-1:0] vr [0:PROD_W];
  logic [PROD_W-1:0] vq [0:PROD_W];
  logic [DEN1_W-1:0] vd [0:PROD_W];
  ntc_side_t         s1 [0:PROD_W];

  assign tn[0] = f_tnum_q;
  assign tr[0] = '0;
  assign tq[0] = '0;
  assign td[0] = f_tden_q;
  assign vn[0] = f_inum_q;
  assign vr[0] = '0;
  assign vq[0] = '0;
  assign vd[0] = f_iden_q;
  assign s1[0] = f_side_q;

  for (genvar i = 0; i < PROD_W; i++) begin : g_div1
    ntc_side_t side_q;

    ntc_div_cell #(.NUM_W(PROD_W), .DEN_W(DEN1_W)) u_term (
      .clk_i, .en_i(en),
      .num_i(tn[i]), .rem_i(tr[i]), .quo_i(tq[i]), .den_i(td[i]),
      .num_o(tn[i+1]), .rem_o(tr[i+1]), .quo_o(tq[i+1]), .den_o(td[i+1])
    );
    ntc_div_cell #(.NUM_W(PROD_W), .DEN_W(DEN1_W)) u_inv0 (
      .clk_i, .en_i(en),
      .num_i(vn[i]), .rem_i(vr[i]), .quo_i(vq[i]), .den_i(vd[i]),
      .num_o(vn[i+1]), .rem_o(vr[i+1]), .quo_o(vq[i+1]), .den_o(vd[i+1])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q <= '0;
      end else if (en) begin
        side_q <= s1[i];
      end
    end

    assign s1[i+1] = side_q;
  end

  // Stage G: 1/T = 1/T0 +- term; flag a non-positive sum for saturation
  logic signed [INV_W:0] inv_s;
  logic [INV_W-1:0]      inv_u;
  ntc_side_t             g_side_q;
  logic [TK_W-1:0]       g_num_q;
  logic [INV_W-1:0]      g_den_q;

  always_comb begin
    if (s1[PROD_W].flag) begin
      inv_s = $signed({1'b0, INV_W'(vq[PROD_W][ONE_W-1:0])})
            - $signed({1'b0, INV_W'(tq[PROD_W][TERM_W-1:0])});
    end else begin
      inv_s = $signed({1'b0, INV_W'(vq[PROD_W][ONE_W-1:0])})
            + $signed({1'b0, INV_W'(tq[PROD_W][TERM_W-1:0])});
    end
    inv_u = inv_s[INV_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_side_q <= '0;
    end else if (en) begin
      g_side_q.valid   <= s1[PROD_W].valid;
      g_side_q.invalid <= s1[PROD_W].invalid;
      g_side_q.flag    <= inv_s <= $signed((INV_W+1)'(0));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      g_num_q <= TK_W'(ONE) + TK_W'(inv_u >> 1);
      g_den_q <= inv_u;
    end
  end

  // Division chain for T in kelvin
  logic [TK_W-1:0]  kn [0:TK_W];
  logic [INV_W-1:0] kr [0:TK_W];
  logic [TK_W-1:0]  kq [0:TK_W];
  logic [INV_W-1:0] kd [0:TK_W];
  ntc_side_t        s2 [0:TK_W];

  assign kn[0] = g_num_q;
  assign kr[0] = '0;
  assign kq[0] = '0;
  assign kd[0] = g_den_q;
  assign s2[0] = g_side_q;

  for (genvar i = 0; i < TK_W; i++) begin : g_div2
    ntc_side_t side_q;

    ntc_div_cell #(.NUM_W(TK_W), .DEN_W(INV_W)) u_tk (
      .clk_i, .en_i(en),
      .num_i(kn[i]), .rem_i(kr[i]), .quo_i(kq[i]), .den_i(kd[i]),
      .num_o(kn[i+1]), .rem_o(kr[i+1]), .quo_o(kq[i+1]), .den_o(kd[i+1])
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q <= '0;
      end else if (en) begin
        side_q <= s2[i];
      end
    end

    assign s2[i+1] = side_q;
  end

  // Output: kelvin to degC, saturate, force zero on a bad reading
  logic signed [ONE_W:0]  temp_s;
  logic [TEMP_W-1:0]      temp_c;
  logic [TEMP_W-1:0]      temp_q;
  logic                   invalid_q;

  always_comb begin
    temp_s = $signed({1'b0, kq[TK_W][ONE_W-1:0]}) - $signed((ONE_W+1)'(KOFF));
    if (s2[TK_W].invalid) begin
      temp_c = '0;
    end else if (s2[TK_W].flag || temp_s > $signed((ONE_W+1)'(32767))) begin
      temp_c = 16'h7FFF;
    end else if (temp_s < -$signed((ONE_W+1)'(32768))) begin
      temp_c = 16'h8000;
    end else begin
      temp_c = temp_s[TEMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= s2[TK_W].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && s2[TK_W].valid) begin
      temp_q    <= temp_c;
      invalid_q <= s2[TK_W].invalid;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign temperature_out_o = $signed(temp_q);
  assign invalid_o         = invalid_q;

endmodule

[hw/rtl/ntc_checker.sv]
// Port-level checks for the NTC temperature block, bound to the top level.
// Depends on ntc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module ntc_checker import ntc_pkg::*; (
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     in_valid_i,
  input logic                     in_stall_o,
  input logic [SIG_W-1:0]         signal_code_i,
  input logic [SIG_W-1:0]         reference_code_i,
  input logic                     out_valid_o,
  input logic                     out_stall_i,
  input logic signed [TEMP_W-1:0] temperature_out_o,
  input logic                     invalid_o
);

  // A bad reading always reports zero degrees
  `NTC_IMPLIES(a_invalid_zero, out_valid_o && invalid_o, temperature_out_o == '0, "invalid result with nonzero temperature")
  // The input side only stalls behind a full, stalled output register
  `NTC_IMPLIES(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "input stalled without output backpressure")
  // A stalled result holds
  `NTC_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(temperature_out_o) && $stable(invalid_o)), "stalled result changed")
  // A stalled input transfer holds
  `NTC_ASSERT(a_in_hold, (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(signal_code_i) && $stable(reference_code_i)), "stalled input changed")

endmodule

bind ntc_thermistor_temperature ntc_checker u_ntc_checker (.*);

[sim/testbench.sv]
`timescale 1ns / 1ps
// Self-checking testbench for ntc_thermistor_temperature: random and directed ADC code
// pairs under several register settings, checked against a fixed-point beta-equation model.
// Depends on ntc_pkg and the block's RTL.

import ntc_pkg::*;

typedef struct {
  logic signed [TEMP_W-1:0] temp;
  logic                     bad;
} ntc_reading_t;

// Holds a copy of the registers, predicts each transfer and checks results in order.
class ntc_scoreboard;
  logic [BETA_W-1:0]        beta;
  logic signed [TEMP_W-1:0] nom_temp;
  logic [RES_W-1:0]         series_r;
  logic [RES_W-1:0]         nom_r;
  ntc_reading_t             pending[$];
  int                       checked;
  int                       flagged;

  function new();
    beta     = BETA_RST;
    nom_temp = NOM_TEMP_RST;
    series_r = SERIES_RST;
    nom_r    = NOM_RES_RST;
    checked  = 0;
    flagged  = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_BETA:     beta = data[BETA_W-1:0];
      CFG_NOM_TEMP: nom_temp = data[TEMP_W-1:0];
      CFG_SERIES:   series_r = data[RES_W-1:0];
      CFG_NOM_RES:  nom_r = data[RES_W-1:0];
      default: ;
    endcase
  endfunction

  // log2 with 24 fraction bits by repeated squaring of a Q31 mantissa
  function bit [63:0] log2_q24(bit [63:0] x);
    int       pos;
    bit [63:0] m;
    bit [63:0] res;
    pos = 0;
    for (int i = 0; i < 64; i++) if (x[i]) pos = i;
    m = (pos <= 31) ? (x << (31 - pos)) : (x >> (pos - 31));
    res = 64'(pos) << 24;
    for (int i = 23; i >= 0; i--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        res[i] = 1'b1;
      end
    end
    return res;
  endfunction

  function ntc_reading_t temperature_of(bit [SIG_W-1:0] sig, bit [SIG_W-1:0] refc);
    ntc_reading_t r;
    longint       koff;
    bit [63:0]    one, rs, r0, bt, inv0, lx, ly, mag, den, term, tk;
    longint       t0k, inv, t;
    bit           neg;
    koff = (2731 * (64'd1 << FRAC_BITS_DEF) + 5) / 10;
    one  = 64'd1 << (40 + FRAC_BITS_DEF);
    r.bad = 1'b0;
    if (sig == 0 || sig >= refc) begin
      r.temp = '0;
      r.bad  = 1'b1;
      return r;
    end
    rs = (series_r == 0) ? 1 : series_r;
    r0 = (nom_r == 0) ? 1 : nom_r;
    bt = (beta == 0) ? 1 : beta;
    t0k = longint'(nom_temp) + koff;
    if (t0k < 1) t0k = 1;
    inv0 = (one + 64'(t0k) / 2) / 64'(t0k);
    lx = log2_q24(rs * sig);
    ly = log2_q24(64'(refc - sig) * r0);
    neg = lx < ly;
    mag = neg ? ly - lx : lx - ly;
    den = bt << 16;
    term = (mag * 64'(LN2_Q32) + den / 2) / den;
    inv = neg ? longint'(inv0) - longint'(term) : longint'(inv0) + longint'(term);
    if (inv <= 0) begin
      t = 32767;
    end else begin
      tk = (one + 64'(inv) / 2) / 64'(inv);
      t = longint'(tk) - koff;
      if (t > 32767) t = 32767;
      if (t < -32768) t = -32768;
    end
    r.temp = t[TEMP_W-1:0];
    return r;
  endfunction

  function void note_input(bit [SIG_W-1:0] sig, bit [SIG_W-1:0] refc);
    pending.push_back(temperature_of(sig, refc));
  endfunction

  // Return an empty string on a match, else a description of the mismatch.
  function string check_result(logic signed [TEMP_W-1:0] temp, logic bad);
    ntc_reading_t e;
    checked++;
    if (bad) flagged++;
    if (pending.size() == 0) return $sformatf("unexpected result temp=%0d invalid=%b", temp, bad);
    e = pending.pop_front();
    if (temp !== e.temp || bad !== e.bad)
      return $sformatf("temp=%0d invalid=%b, want temp=%0d invalid=%b",
                       temp, bad, e.temp, e.bad);
    return "";
  endfunction
endclass

module testbench;
  logic                     clk_i;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_stall_o;
  logic [SIG_W-1:0]         signal_code_i;
  logic [SIG_W-1:0]         reference_code_i;
  logic                     out_valid_o;
  logic                     out_stall_i;
  logic signed [TEMP_W-1:0] temperature_out_o;
  logic                     invalid_o;
  logic                     cfg_we_i;
  logic [CFG_IDX_W-1:0]     cfg_index_i;
  logic [CFG_W-1:0]         cfg_data_i;

  // Pipeline depth plus a margin, used when settling.
  localparam int SETTLE = FRAC_BITS_DEF + 137 + 60;

  ntc_scoreboard sb;
  int            fails;
  int            sent;
  int            settings;
  bit            quiet;

  ntc_thermistor_temperature dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Safety net: end the run if the handshake ever hangs.
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic report(string msg);
    fails++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Receiver: check every transfer, stall at random outside the quiet stretch.
  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      msg = sb.check_result(temperature_out_o, invalid_o);
      if (msg != "") report(msg);
    end
    out_stall_i <= quiet ? 1'b0 : ($urandom_range(99) < 31);
  end

  // Present one code pair; hold it until the block takes the transfer.
  task automatic send(bit [SIG_W-1:0] sig, bit [SIG_W-1:0] refc);
    while (!quiet && $urandom_range(99) < 31) begin
      in_valid_i <= 1'b0;
      signal_code_i <= SIG_W'($urandom);
      reference_code_i <= SIG_W'($urandom);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    signal_code_i <= sig;
    reference_code_i <= refc;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input(sig, refc);
    sent++;
  endtask

  // Random pair: mostly in-range signals, some invalid ones.
  task automatic send_random();
    bit [SIG_W-1:0] r, s;
    r = SIG_W'($urandom);
    if ($urandom_range(99) < 80 && r > 1) s = SIG_W'($urandom_range(r - 1, 1));
    else s = SIG_W'($urandom);
    send(s, r);
  endtask

  // Drop valid and wait until every expected result is back, then let the pipe empty.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write all four registers on back-to-back cycles; junk goes in the unused high bits of beta and nominal temperature.
  task automatic write_regs(bit [15:0] beta, bit [15:0] t0, bit [19:0] rs, bit [19:0] r0);
    logic [CFG_W-1:0] vals[4];
    vals[CFG_BETA]     = {4'($urandom), beta};
    vals[CFG_NOM_TEMP] = {4'($urandom), t0};
    vals[CFG_SERIES]   = rs;
    vals[CFG_NOM_RES]  = r0;
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= CFG_IDX_W'(i);
      cfg_data_i <= vals[i];
      @(posedge clk_i);
      sb.set_reg(CFG_IDX_W'(i), vals[i]);
    end
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  task automatic directed();
    send(0, 0);
    send(0, 100);
    send(100, 100);
    send(200, 100);
    send(32767, 32767);
    send(0, 32767);
    send(1, 32767);
    send(32766, 32767);
    send(1, 2);
    send(16383, 32767);
    send(16384, 32767);
    send(100, 200);
    send(1000, 30000);
    send(29000, 30000);
    send(21845, 32767);
  endtask

  initial begin
    sb = new();
    fails = 0;
    sent = 0;
    settings = 0;
    quiet = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    signal_code_i = '0;
    reference_code_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_BETA;
    cfg_data_i = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults first.
    directed();
    repeat (80) send_random();
    drain();

    // Extremes: smallest beta, coldest T0, smallest resistors.
    write_regs(16'd1, 16'h8000, 20'd1, 20'd1);
    directed();
    repeat (60) send_random();
    drain();

    // Largest beta, hottest T0, largest series resistor and a large nominal one.
    write_regs(16'hFFFF, 16'h7FFF, 20'hFFFFF, 20'd1000000);
    directed();
    repeat (60) send_random();
    drain();

    // Zero beta and zero resistors act as one; run this phase with no idling at all.
    write_regs(16'd0, 16'd0, 20'd0, 20'd0);
    quiet = 1'b1;
    directed();
    repeat (60) send_random();
    drain();
    quiet = 1'b0;

    // Skewed divider: tiny series resistor against a huge nominal one and vice versa.
    write_regs(16'd3435, 16'(-10240), 20'd1, 20'd1000000);
    repeat (50) send_random();
    drain();
    write_regs(16'd4250, 16'd25600, 20'd1000000, 20'd1);
    repeat (50) send_random();
    drain();

    // Fully random settings.
    repeat (4) begin
      write_regs(16'($urandom), 16'($urandom), 20'($urandom), 20'($urandom));
      repeat (40) send_random();
      drain();
    end

    $display("Sent %0d code pairs over %0d register settings; %0d results checked, %0d invalid.",
             sent, settings, sb.checked, sb.flagged);
    if (fails == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/ntc_pkg.sv
hw/rtl/ntc_log_cell.sv
hw/rtl/ntc_div_cell.sv
hw/rtl/ntc_thermistor_temperature.sv
hw/rtl/ntc_checker.sv
sim/testbench.sv
